// ===== rtl/core/mtw_pkg.sv =====
// Package for the MT19937 word generator: widths, tap positions, the
// twist and tempering constants, and the types shared by its modules.
// No dependencies.
package mtw_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned COUNT_W     = 7;
   localparam int unsigned STATE_DEPTH = 624;
   localparam int unsigned TAP_NEXT    = 1;
   localparam int unsigned TAP_FAR     = 397;
   localparam int unsigned POS_W       = $clog2(STATE_DEPTH + 1);
   localparam int unsigned MAX_BURST   = 64;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned REG_IDX_W   = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_SEED = '0;

   localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;
   localparam logic [WORD_W-1:0] FILL_MULT  = 32'd1812433253;
   localparam logic [WORD_W-1:0] TW_MATRIX  = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] TW_UPPER   = 32'h8000_0000;
   localparam logic [WORD_W-1:0] TW_LOWER   = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_IDLE,
      ST_BURST
   } seq_state_type;

   // Control from the sequencer to the row of state cells.
   typedef struct packed {
      logic             shift;
      logic             fill;
      logic [POS_W-1:0] fill_idx;
   } chain_ctl_type;

   // Status from the sequencer to the output stage.
   typedef struct packed {
      logic emit;
      logic rsp_valid;
      logic rsp_last;
   } seq_status_type;

   function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] w_cur,
                                                    input logic [WORD_W-1:0] w_next,
                                                    input logic [WORD_W-1:0] w_far);
      logic [WORD_W-1:0] y;
      y = (w_cur & TW_UPPER) | (w_next & TW_LOWER);
      twist_word = w_far ^ (y >> 1) ^ (y[0] ? TW_MATRIX : '0);
   endfunction

   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      temper = y ^ (y >> 18);
   endfunction

endpackage

// ===== rtl/core/mtw_req_if.sv =====
// Request channel of the MT19937 word generator: valid, ready and the
// requested word count. Depends on mtw_pkg.
interface mtw_req_if;
   import mtw_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] word_count;

   modport source (output valid, output word_count, input ready);
   modport sink   (input valid, input word_count, output ready);
endinterface

// ===== rtl/core/mtw_rsp_if.sv =====
// Result channel of the MT19937 word generator: valid, ready, the tempered
// word and the end-of-burst flag. Depends on mtw_pkg.
interface mtw_rsp_if;
   import mtw_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] random_word;
   logic              last_word;

   modport source (output valid, output random_word, output last_word, input ready);
   modport sink   (input valid, input random_word, input last_word, output ready);
endinterface

// ===== rtl/core/mtw_cell.sv =====
// One state cell of the generator: a 32-bit word that takes its neighbor's
// word whenever the row shifts. Depends on mtw_pkg.
module mtw_cell (
   input  logic                      clock,
   input  logic                      shift,
   input  logic [mtw_pkg::WORD_W-1:0] d,
   output logic [mtw_pkg::WORD_W-1:0] q
);
   import mtw_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   assign word_in = shift ? d : word_ff;

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign q = word_ff;
endmodule

// ===== rtl/core/mtw_chain.sv =====
// Row of 624 state cells with the feed logic at its tail: the seed fill
// recurrence and the twist recurrence. Depends on mtw_pkg and mtw_cell.
module mtw_chain (
   input  logic                      clock,
   input  mtw_pkg::chain_ctl_type    ctl,
   input  logic [mtw_pkg::WORD_W-1:0] seed,
   output logic [mtw_pkg::WORD_W-1:0] new_word
);
   import mtw_pkg::*;

   logic [WORD_W-1:0] cell_q [STATE_DEPTH];
   logic [WORD_W-1:0] feed;
   logic [WORD_W-1:0] tail;
   logic [WORD_W-1:0] fill_prod;
   logic [WORD_W-1:0] fill_word;

   // The head cell holds the oldest word; the tail takes the newest.
   assign tail     = cell_q[STATE_DEPTH-1];
   assign new_word = twist_word(cell_q[0], cell_q[TAP_NEXT], cell_q[TAP_FAR]);

   assign fill_prod = FILL_MULT * (tail ^ (tail >> 30));
   assign fill_word = (ctl.fill_idx == '0) ? seed : fill_prod + WORD_W'(ctl.fill_idx);
   assign feed      = ctl.fill ? fill_word : new_word;

   for (genvar i = 0; i < STATE_DEPTH; i++) begin : g_cell
      if (i == STATE_DEPTH - 1) begin : g_tail
         mtw_cell u_cell (
            .clock (clock),
            .shift (ctl.shift),
            .d     (feed),
            .q     (cell_q[i])
         );
      end else begin : g_body
         mtw_cell u_cell (
            .clock (clock),
            .shift (ctl.shift),
            .d     (cell_q[i+1]),
            .q     (cell_q[i])
         );
      end
   end
endmodule

// ===== rtl/core/mtw_seq.sv =====
// Sequencer of the generator: seed fill, request acceptance, burst count
// and the result valid/last flags. Depends on mtw_pkg.
module mtw_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       seed_write,
   input  logic                       req_valid,
   input  logic [mtw_pkg::COUNT_W-1:0] req_count,
   output logic                       req_ready,
   input  logic                       rsp_ready,
   output mtw_pkg::chain_ctl_type     ctl,
   output mtw_pkg::seq_status_type    status
);
   import mtw_pkg::*;

   seq_state_type      state_ff, state_in;
   logic [POS_W-1:0]   fill_idx_ff, fill_idx_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_last_ff, out_last_in;
   logic [COUNT_W-1:0] sat_count;
   logic               req_fire;
   logic               emit;

   // Requests above the burst limit are trimmed to it.
   assign sat_count = (req_count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST) : req_count;
   assign req_fire  = (state_ff == ST_IDLE) && req_valid;
   assign emit      = (state_ff == ST_BURST) && (!out_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (fill_idx_ff == POS_W'(STATE_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire && (sat_count != '0)) state_in = ST_BURST;
         end
         ST_BURST: begin
            if (emit && (remain_ff == COUNT_W'(1))) state_in = ST_IDLE;
         end
         default: state_in = ST_FILL;
      endcase
      if (seed_write) state_in = ST_FILL;
   end

   // Outputs of the state machine.
   always_comb begin
      req_ready    = 1'b0;
      ctl.shift    = 1'b0;
      ctl.fill     = 1'b0;
      ctl.fill_idx = fill_idx_ff;
      unique case (state_ff)
         ST_FILL: begin
            ctl.shift = 1'b1;
            ctl.fill  = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_BURST: begin
            ctl.shift = emit;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      fill_idx_in  = fill_idx_ff;
      remain_in    = remain_ff;
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      if (seed_write) begin
         fill_idx_in = '0;
      end else if (state_ff == ST_FILL) begin
         fill_idx_in = fill_idx_ff + POS_W'(1);
      end
      if (req_fire) begin
         remain_in = sat_count;
      end else if (emit) begin
         remain_in = remain_ff - COUNT_W'(1);
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_last_in  = (remain_ff == COUNT_W'(1));
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_idx_ff  <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_idx_ff  <= fill_idx_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign status.emit      = emit;
   assign status.rsp_valid = out_valid_ff;
   assign status.rsp_last  = out_last_ff;
endmodule

// ===== rtl/core/mt19937_word_generator.sv =====
// Top level of the MT19937 word generator: seed register on the APB-style
// port, sequencer, state cell row and the tempered output register.
// Depends on mtw_pkg, mtw_req_if, mtw_rsp_if, mtw_seq and mtw_chain.

// This block produces the standard 32-bit MT19937 sequence. The 624 state
// words live in a row of cells that shifts by one word for each word made:
// the tail takes the twist of the head cell, its neighbor and the cell 397
// places on, which is exactly the next word of the sequence, so the twist
// is spread one word per cycle while results are taken, and never stalls
// a burst. After reset, and after every write of the seed register (byte
// address 0), the row is refilled from the seed with the 1812433253
// recurrence through the same shift path, during which no request item is
// accepted. A request item asks for word_count words (values above 64 are
// taken as 64, and zero gives no words). Once the item is accepted, its
// words leave one per cycle through the output register while the result
// side does not stall, the final one flagged by last_word; the shift of the
// cell row sets this one-word-per-cycle rate. The last word of a burst may
// still wait in the output register while the next item is accepted.
// Reading the seed register returns the value last written, 5489 after
// reset.
module mt19937_word_generator (
   input  logic                          clock,
   input  logic                          reset,
   mtw_req_if.sink                       req_ch,
   mtw_rsp_if.source                     rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mtw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mtw_pkg::WORD_W-1:0]     csr_pwdata,
   output logic [mtw_pkg::WORD_W-1:0]     csr_prdata,
   output logic                          csr_pready
);
   import mtw_pkg::*;

   logic [WORD_W-1:0]    seed_ff, seed_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [REG_IDX_W-1:0] csr_index;
   logic                 seed_write;
   logic [WORD_W-1:0]    new_word;
   chain_ctl_type        ctl;
   seq_status_type       status;

   // The port never waits; a write lands on the access cycle. The low two
   // address bits are ignored and do not pick a register.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign seed_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_index == REG_SEED);
   assign csr_prdata = (csr_index == REG_SEED) ? seed_ff : '0;

   assign seed_in = seed_write ? csr_pwdata : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mtw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .seed_write (seed_write),
      .req_valid  (req_ch.valid),
      .req_count  (req_ch.word_count),
      .req_ready  (req_ch.ready),
      .rsp_ready  (rsp_ch.ready),
      .ctl        (ctl),
      .status     (status)
   );

   mtw_chain u_chain (
      .clock    (clock),
      .ctl      (ctl),
      .seed     (seed_ff),
      .new_word (new_word)
   );

   // The freshly twisted word is tempered on its way into the output
   // register, in the same cycle that it enters the tail of the row.
   assign word_in = status.emit ? temper(new_word) : word_ff;

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_ch.valid       = status.rsp_valid;
   assign rsp_ch.random_word = word_ff;
   assign rsp_ch.last_word   = status.rsp_last;
endmodule
